// File: design/dbft_pkg.sv
// Shared types and constants for the dual bounded FIFO transfer core.
// No dependencies; every other design file imports this package.
package dbft_pkg;

  localparam int WORD_W     = 32;
  localparam int FUNC_W     = 3;
  localparam int CAP_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int DBFT_DEPTH = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

  // Operation codes carried in the func field
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FIRST  = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_TRANSFER    = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_POP_SECOND  = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] FUNC_READ_FIRST  = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] FUNC_READ_SECOND = FUNC_W'(4);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_FIRST  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_SECOND = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DROPPED   = 2'd3
  } dbft_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_XFER,
    S_POP,
    S_READ
  } dbft_state_t;

  // Per-queue command from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic rd_en;
  } dbft_qcmd_t;

endpackage

// File: design/dbft_if.sv
// Handshake channel interfaces: input items, result items, configuration writes.
// Depends on dbft_pkg for field widths.
interface dbft_in_if;
  import dbft_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;
  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface dbft_out_if;
  import dbft_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] data;
  logic                     last;
  modport source (output valid, status, data, last, input ready);
  modport sink   (input valid, status, data, last, output ready);
endinterface

interface dbft_cfg_if;
  import dbft_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CAP_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/dbft_queue.sv
// One bounded circular queue: word memory with a registered read port,
// head pointer, fill count and full flag. Depends on dbft_pkg.
module dbft_queue #(
  parameter int  DEPTH = dbft_pkg::DBFT_DEPTH,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [dbft_pkg::CAP_W-1:0]  cap,
  input  dbft_pkg::dbft_qcmd_t        cmd,
  input  logic [dbft_pkg::WORD_W-1:0] push_data,
  input  logic [AW-1:0]               rd_ofs,
  output logic [dbft_pkg::WORD_W-1:0] rd_data,
  output logic [CW-1:0]               count,
  output logic                        full
);
  import dbft_pkg::*;

  localparam int MW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [AW:0]    DEPTH_X   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0]  HEAD_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0]  COUNT_MAX = CW'(DEPTH);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [AW-1:0]     head;
  logic [AW:0]       rd_sum;
  logic [AW:0]       wr_sum;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;

  always_comb begin
    rd_sum  = {1'b0, head} + {1'b0, rd_ofs};
    wr_sum  = {1'b0, head} + (AW + 1)'(count);
    rd_addr = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : rd_sum[AW-1:0];
    wr_addr = (wr_sum >= DEPTH_X) ? AW'(wr_sum - DEPTH_X) : wr_sum[AW-1:0];
  end

  // Capacity 0 acts as 1, capacity above DEPTH acts as DEPTH
  always_comb begin
    if (cap == '0) begin
      full = (count != '0);
    end else begin
      full = (MW'(count) >= MW'(cap)) || (count == COUNT_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CW'(1);
    end else if (cmd.pop) begin
      head  <= (head == HEAD_LAST) ? '0 : head + AW'(1);
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= push_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/dbft_ctrl.sv
// Sequencer: takes one item, drives both queues through their shared read
// offset, and fills the result register. Depends on dbft_pkg and dbft_if.
module dbft_ctrl #(
  parameter int  DEPTH = dbft_pkg::DBFT_DEPTH,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  dbft_in_if.sink                     item,
  dbft_out_if.source                  result,
  input  logic [CW-1:0]               count_first,
  input  logic                        full_first,
  input  logic [dbft_pkg::WORD_W-1:0] rd_data_first,
  input  logic [CW-1:0]               count_second,
  input  logic                        full_second,
  input  logic [dbft_pkg::WORD_W-1:0] rd_data_second,
  output dbft_pkg::dbft_qcmd_t        cmd_first,
  output dbft_pkg::dbft_qcmd_t        cmd_second,
  output logic [AW-1:0]               rd_ofs,
  output logic [dbft_pkg::WORD_W-1:0] push_word
);
  import dbft_pkg::*;

  dbft_state_t       state;
  dbft_state_t       state_next;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] value;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     idx_next;

  logic              out_valid;
  dbft_status_t      out_status;
  logic [WORD_W-1:0] out_data;
  logic              out_last;

  logic              out_free;
  logic              accept;
  logic              func_known;
  logic              read_first;
  logic [CW-1:0]     sel_count;
  logic [WORD_W-1:0] sel_data;
  logic              is_last;

  logic              emit;
  dbft_status_t      emit_status;
  logic [WORD_W-1:0] emit_data;
  logic              emit_last;

  assign item.ready    = (state == S_IDLE);
  assign accept        = item.valid && item.ready;
  assign out_free      = !out_valid || result.ready;
  assign func_known    = (item.func == FUNC_PUSH_FIRST) || (item.func == FUNC_TRANSFER) ||
                         (item.func == FUNC_POP_SECOND) || (item.func == FUNC_READ_FIRST) ||
                         (item.func == FUNC_READ_SECOND);
  assign read_first    = (func == FUNC_READ_FIRST);
  assign sel_count     = read_first ? count_first : count_second;
  assign sel_data      = read_first ? rd_data_first : rd_data_second;
  assign is_last       = (CW'(idx) + CW'(1)) == sel_count;

  assign result.valid  = out_valid;
  assign result.status = out_status;
  assign result.data   = out_data;
  assign result.last   = out_last;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && func_known) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          case (func)
            FUNC_TRANSFER:   state_next = (count_first == '0) ? S_IDLE : S_XFER;
            FUNC_POP_SECOND: state_next = (count_second == '0) ? S_IDLE : S_POP;
            FUNC_READ_FIRST,
            FUNC_READ_SECOND: state_next = (sel_count == '0) ? S_IDLE : S_READ;
            default:         state_next = S_IDLE;
          endcase
        end
      end
      S_XFER, S_POP: begin
        if (out_free) state_next = S_IDLE;
      end
      S_READ: begin
        if (out_free && is_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Queue commands and result loading
  always_comb begin
    cmd_first   = '0;
    cmd_second  = '0;
    rd_ofs      = '0;
    idx_next    = idx;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_data   = '0;
    emit_last   = 1'b1;
    push_word   = (state == S_XFER) ? rd_data_first : value;
    case (state)
      S_EXEC: begin
        if (out_free) begin
          case (func)
            FUNC_PUSH_FIRST: begin
              emit = 1'b1;
              if (full_first) begin
                emit_status = ST_OVERFLOW;
              end else begin
                cmd_first.push = 1'b1;
              end
            end
            FUNC_TRANSFER: begin
              if (count_first == '0) begin
                emit        = 1'b1;
                emit_status = ST_UNDERFLOW;
              end else begin
                cmd_first.rd_en = 1'b1;
              end
            end
            FUNC_POP_SECOND: begin
              if (count_second == '0) begin
                emit        = 1'b1;
                emit_status = ST_UNDERFLOW;
              end else begin
                cmd_second.rd_en = 1'b1;
              end
            end
            FUNC_READ_FIRST, FUNC_READ_SECOND: begin
              if (sel_count == '0) begin
                emit        = 1'b1;
                emit_status = ST_UNDERFLOW;
              end else if (read_first) begin
                cmd_first.rd_en = 1'b1;
              end else begin
                cmd_second.rd_en = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_XFER: begin
        if (out_free) begin
          emit          = 1'b1;
          cmd_first.pop = 1'b1;
          if (full_second) begin
            emit_status = ST_DROPPED;
          end else begin
            cmd_second.push = 1'b1;
            emit_data       = rd_data_first;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          emit           = 1'b1;
          cmd_second.pop = 1'b1;
          emit_data      = rd_data_second;
        end
      end
      S_READ: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = sel_data;
          emit_last = is_last;
          if (!is_last) begin
            // fetch the next word while this one goes out
            idx_next = idx + AW'(1);
            rd_ofs   = idx + AW'(1);
            if (read_first) begin
              cmd_first.rd_en = 1'b1;
            end else begin
              cmd_second.rd_en = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      idx   <= accept ? '0 : idx_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func  <= item.func;
      value <= item.value;
    end
    if (emit) begin
      out_status <= emit_status;
      out_data   <= emit_data;
      out_last   <= emit_last;
    end
  end

endmodule

// File: design/dual_bounded_fifo_transfer_core.sv
// Two bounded FIFOs of 32-bit words with a transfer path from the first to
// the second. One item is handled at a time. With the result register free,
// push loads its result in S_EXEC; transfer and pop read the queue head in
// S_EXEC and load their result in S_XFER or S_POP; a readout reads its first
// word in S_EXEC and loads each word in S_READ while it fetches the next. An
// empty transfer, pop or readout loads its underflow result in S_EXEC. The
// block is ready again in the cycle after an item's last result is loaded.
// Each queue memory has a registered read port, which the sequencer visits
// once per word. Results wait in an output register until taken; a result
// waiting there holds the sequencer. Configuration writes are taken in every
// cycle. Depends on dbft_pkg, dbft_if, dbft_queue and dbft_ctrl.
module dual_bounded_fifo_transfer_core #(
  parameter int DEPTH = dbft_pkg::DBFT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  dbft_in_if.sink     item,
  dbft_out_if.source  result,
  dbft_cfg_if.sink    cfg
);
  import dbft_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0]  cap_first;
  logic [CAP_W-1:0]  cap_second;
  dbft_qcmd_t        cmd_first;
  dbft_qcmd_t        cmd_second;
  logic [AW-1:0]     rd_ofs;
  logic [WORD_W-1:0] push_word;
  logic [WORD_W-1:0] rd_data_first;
  logic [WORD_W-1:0] rd_data_second;
  logic [CW-1:0]     count_first;
  logic [CW-1:0]     count_second;
  logic              full_first;
  logic              full_second;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_first  <= CAP_RESET;
      cap_second <= CAP_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_CAP_FIRST)  cap_first  <= cfg.data;
      if (cfg.index == CFG_CAP_SECOND) cap_second <= cfg.data;
    end
  end

  dbft_queue #(.DEPTH(DEPTH)) u_queue_first (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap_first),
    .cmd       (cmd_first),
    .push_data (push_word),
    .rd_ofs    (rd_ofs),
    .rd_data   (rd_data_first),
    .count     (count_first),
    .full      (full_first)
  );

  dbft_queue #(.DEPTH(DEPTH)) u_queue_second (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap_second),
    .cmd       (cmd_second),
    .push_data (push_word),
    .rd_ofs    (rd_ofs),
    .rd_data   (rd_data_second),
    .count     (count_second),
    .full      (full_second)
  );

  dbft_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item           (item),
    .result         (result),
    .count_first    (count_first),
    .full_first     (full_first),
    .rd_data_first  (rd_data_first),
    .count_second   (count_second),
    .full_second    (full_second),
    .rd_data_second (rd_data_second),
    .cmd_first      (cmd_first),
    .cmd_second     (cmd_second),
    .rd_ofs         (rd_ofs),
    .push_word      (push_word)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for dual_bounded_fifo_transfer_core.
// Depends on dbft_pkg and the dbft_if channel interfaces. An internal queue predictor
// supplies the expected results, which are compared with the result channel.
`timescale 1ns / 100ps

module tb;
  import dbft_pkg::*;

  localparam int DEPTH = DBFT_DEPTH;

  // Func codes with no operation behind them
  localparam logic [FUNC_W-1:0] FUNC_RSVD_A = FUNC_W'(5);
  localparam logic [FUNC_W-1:0] FUNC_RSVD_C = FUNC_W'(7);
  // Config index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  typedef struct {
    dbft_status_t             status;
    logic signed [WORD_W-1:0] data;
    logic                     last;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  dbft_in_if  item_if ();
  dbft_out_if result_if ();
  dbft_cfg_if cfg_if ();

  dual_bounded_fifo_transfer_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [WORD_W-1:0] mem_first [DEPTH];
  logic [WORD_W-1:0] mem_second [DEPTH];
  int unsigned       head_first, fill_first, head_second, fill_second;
  logic [CAP_W-1:0]  cap_first, cap_second;

  queue_result_t awaited_results[$];
  int            errors;
  int            in_idle_pct;
  int            out_idle_pct;
  int            stall_left;

  function automatic int unsigned usable_cap(logic [CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > DEPTH) return DEPTH;
    return c;
  endfunction

  function automatic void expect_result(dbft_status_t st, logic [WORD_W-1:0] d, logic lst);
    queue_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    awaited_results.push_back(r);
  endfunction

  function automatic void expect_readout(bit from_second);
    int unsigned hd;
    int unsigned n;
    hd = from_second ? head_second : head_first;
    n  = from_second ? fill_second : fill_first;
    if (n == 0) begin
      expect_result(ST_UNDERFLOW, '0, 1'b1);
    end else begin
      for (int unsigned i = 0; i < n; i++)
        expect_result(ST_OK, from_second ? mem_second[(hd + i) % DEPTH]
                                         : mem_first[(hd + i) % DEPTH], i + 1 == n);
    end
  endfunction

  function automatic void predict_queue_op(logic [FUNC_W-1:0] f, logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] w;
    case (f)
      FUNC_PUSH_FIRST: begin
        if (fill_first >= usable_cap(cap_first)) begin
          expect_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          mem_first[(head_first + fill_first) % DEPTH] = v;
          fill_first++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      FUNC_TRANSFER: begin
        if (fill_first == 0) begin
          expect_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          w          = mem_first[head_first];
          head_first = (head_first + 1) % DEPTH;
          fill_first--;
          // a full second queue swallows the word
          if (fill_second >= usable_cap(cap_second)) begin
            expect_result(ST_DROPPED, '0, 1'b1);
          end else begin
            mem_second[(head_second + fill_second) % DEPTH] = w;
            fill_second++;
            expect_result(ST_OK, w, 1'b1);
          end
        end
      end
      FUNC_POP_SECOND: begin
        if (fill_second == 0) begin
          expect_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          expect_result(ST_OK, mem_second[head_second], 1'b1);
          head_second = (head_second + 1) % DEPTH;
          fill_second--;
        end
      end
      FUNC_READ_FIRST:  expect_readout(1'b0);
      FUNC_READ_SECOND: expect_readout(1'b1);
      default: ;
    endcase
  endfunction

  function automatic void log_mismatch(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // Result-side backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
      stall_left = $urandom_range(0, 7);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // Signals are stable at the falling edge; a handshake seen here completes at the
  // next rising edge.
  always @(negedge clk) begin
    queue_result_t exp_r;
    if (!rst && result_if.valid && result_if.ready) begin
      if (awaited_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result status %0d data %0d last %0b",
                               result_if.status, result_if.data, result_if.last));
      end else begin
        exp_r = awaited_results.pop_front();
        if (result_if.status !== exp_r.status || result_if.data !== exp_r.data ||
            result_if.last !== exp_r.last)
          log_mismatch($sformatf({"status exp %0d got %0d, data exp %0d got %0d, ",
                                  "last exp %0b got %0b"},
                                 exp_r.status, result_if.status, exp_r.data, result_if.data,
                                 exp_r.last, result_if.last));
      end
    end
  end

  // Called at a rising edge; returns at the rising edge where the transaction completes.
  // Valid stays high so the next item can follow without a gap.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic signed [WORD_W-1:0] v);
    if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.func  <= f;
    item_if.value <= v;
    @(negedge clk);
    while (!item_if.ready) @(negedge clk);
    @(posedge clk);
    predict_queue_op(f, v);
  endtask

  // Hold off the sender until every expected result is back, then let the core go idle.
  task automatic settle();
    item_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_caps(input logic [CAP_W-1:0] cf, input logic [CAP_W-1:0] cs,
                            input bit poke_spare);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CAP_W-1:0]     val [3];
    int                   n;
    idx[0] = CFG_CAP_FIRST;
    val[0] = cf;
    idx[1] = CFG_CAP_SECOND;
    val[1] = cs;
    idx[2] = CFG_SPARE;
    val[2] = CAP_W'($urandom);
    n = poke_spare ? 3 : 2;
    for (int k = 0; k < n; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      @(negedge clk);
      while (!cfg_if.ready) @(negedge clk);
      @(posedge clk);
      if (idx[k] == CFG_CAP_FIRST) cap_first = val[k];
      else if (idx[k] == CFG_CAP_SECOND) cap_second = val[k];
    end
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Empty and full queues at reset capacity, dropped transfer, unused codes
  task automatic test_directed_basics();
    in_idle_pct  = 20;
    out_idle_pct = 20;
    send_item(FUNC_READ_FIRST, '0);
    send_item(FUNC_READ_SECOND, '0);
    send_item(FUNC_POP_SECOND, '0);
    send_item(FUNC_TRANSFER, '0);
    send_item(FUNC_PUSH_FIRST, 32'h8000_0000);
    send_item(FUNC_PUSH_FIRST, 32'h7fff_ffff);
    send_item(FUNC_PUSH_FIRST, 32'hffff_ffff);
    send_item(FUNC_PUSH_FIRST, 32'h0000_0000);
    send_item(FUNC_PUSH_FIRST, 32'h5555_5555);
    send_item(FUNC_PUSH_FIRST, 32'haaaa_aaaa);
    send_item(FUNC_READ_FIRST, '0);
    repeat (5) send_item(FUNC_TRANSFER, '0);
    send_item(FUNC_PUSH_FIRST, 32'h1234_5678);
    send_item(FUNC_TRANSFER, '0);
    send_item(FUNC_READ_SECOND, '0);
    send_item(FUNC_POP_SECOND, '0);
    for (int c = FUNC_RSVD_A; c <= FUNC_RSVD_C; c++)
      send_item(FUNC_W'(c), 32'hdead_beef);
    settle();
  endtask

  // Lower the capacities below the stored counts
  task automatic test_capacity_shrink();
    in_idle_pct  = 15;
    out_idle_pct = 15;
    write_caps(4'd8, 4'd8, 1'b0);
    while (fill_first != 0) send_item(FUNC_TRANSFER, '0);
    while (fill_second != 0) send_item(FUNC_POP_SECOND, '0);
    repeat (8) send_item(FUNC_PUSH_FIRST, rand_word());
    repeat (4) send_item(FUNC_TRANSFER, '0);
    settle();
    write_caps(4'd3, 4'd2, 1'b0);
    send_item(FUNC_PUSH_FIRST, rand_word());
    send_item(FUNC_TRANSFER, '0);
    send_item(FUNC_PUSH_FIRST, rand_word());
    send_item(FUNC_READ_FIRST, '0);
    send_item(FUNC_READ_SECOND, '0);
    repeat (2) send_item(FUNC_POP_SECOND, '0);
    repeat (4) send_item(FUNC_TRANSFER, '0);
    send_item(FUNC_PUSH_FIRST, rand_word());
    send_item(FUNC_READ_FIRST, '0);
    repeat (3) send_item(FUNC_POP_SECOND, '0);
    settle();
  endtask

  // Phases alternate between filling and draining; capacities change between phases
  task automatic test_random_mix();
    logic [CAP_W-1:0]  caps_a [6];
    logic [CAP_W-1:0]  caps_b [6];
    logic [FUNC_W-1:0] f;
    int                r;
    int                taken;
    int                push_w;
    int                pop_w;
    caps_a = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd0, 4'd5};
    caps_b = '{4'd15, 4'd0, 4'd1, 4'd8, 4'd0, 4'd9};
    caps_a[4] = CAP_W'($urandom);
    caps_b[4] = CAP_W'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      write_caps(caps_a[ph], caps_b[ph], ph == 2);
      if (ph == 5) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(10, 40);
        out_idle_pct = $urandom_range(10, 40);
      end
      push_w = ph[0] ? 18 : 40;
      pop_w  = ph[0] ? 32 : 12;
      taken  = 0;
      while (taken < 40) begin
        r = $urandom_range(0, 99);
        if (r < 5) f = FUNC_W'(FUNC_RSVD_A + $urandom_range(0, 2));
        else if (r < 5 + push_w) f = FUNC_PUSH_FIRST;
        else if (r < 30 + push_w) f = FUNC_TRANSFER;
        else if (r < 30 + push_w + pop_w) f = FUNC_POP_SECOND;
        else if (r < 30 + push_w + pop_w + (65 - push_w - pop_w) / 2) f = FUNC_READ_FIRST;
        else f = FUNC_READ_SECOND;
        if (f < FUNC_RSVD_A) taken++;
        send_item(f, rand_word());
      end
      settle();
    end
  endtask

  initial begin
    rst             = 1'b1;
    errors          = 0;
    in_idle_pct     = 0;
    out_idle_pct    = 0;
    item_if.valid   = 1'b0;
    item_if.func    = FUNC_PUSH_FIRST;
    item_if.value   = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_CAP_FIRST;
    cfg_if.data     = '0;
    head_first      = 0;
    fill_first      = 0;
    head_second     = 0;
    fill_second     = 0;
    cap_first       = CAP_RESET;
    cap_second      = CAP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_basics();
    test_capacity_shrink();
    test_random_mix();
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
